[sv/nfam_pkg.sv]
package nfam_pkg;

	localparam int NUM_STATES     = 32;
	localparam int ALPHABET_LEN   = 26;
	localparam int ALPHABET_FIRST = 97;

	localparam int ROWS    = NUM_STATES * ALPHABET_LEN;
	localparam int ROW_W   = $clog2(ROWS);
	localparam int SYM_W   = (ALPHABET_LEN > 1) ? $clog2(ALPHABET_LEN) : 1;
	localparam int Q_W     = $clog2(NUM_STATES);
	localparam int CNT_W   = $clog2(NUM_STATES + 1);
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_START_STATE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FINAL_MASK  = 1'b1;

	localparam logic [1:0] KIND_SYMBOL  = 2'd0;
	localparam logic [1:0] KIND_ADD     = 2'd1;
	localparam logic [1:0] KIND_REMOVE  = 2'd2;
	localparam logic [1:0] KIND_RESTART = 2'd3;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_BAD_SYM   = 2'd1;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

	typedef logic [NUM_STATES-1:0] state_set_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] symbol;
		logic [4:0] from_state;
		logic [4:0] to_state;
	} req_item_t;

	typedef struct packed {
		logic       accepted;
		logic       alive;
		logic [1:0] status;
	} rsp_item_t;

	typedef struct packed {
		logic      valid;
		rsp_item_t item;
	} seq_res_t;

	typedef struct packed {
		logic                   we;
		logic [ROW_W-1:0]       waddr;
		state_set_t             wdata;
		logic [ROW_W-1:0]       raddr;
	} mem_req_t;

endpackage

[sv/nfa_state_set_matcher_core.sv]
// Runs a nondeterministic automaton over a symbol stream, keeping the active states as a bit
// vector and the transitions in one table memory with one row of target bits per state and
// symbol. Items are handled one at a time. A restart item or a symbol outside the alphabet
// goes straight to its result, an add or remove edit reads one table row and writes it back
// (a remove only if its bit was set), and a symbol item visits every state, since the single
// read port of the table delivers the row of one state per cycle. After reset the table is
// cleared one row per cycle, all NUM_STATES * ALPHABET_LEN rows (832 as built), during which
// no item is taken; configuration writes are taken at any time. Each result is held in an
// output register so the next item can start while it waits to be taken.
module nfa_state_set_matcher_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  nfam_pkg::req_item_t            req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output nfam_pkg::rsp_item_t            rsp,
	input  logic                           cfg_we,
	input  logic [nfam_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nfam_pkg::CFG_W-1:0]     cfg_data
);

	nfam_pkg::mem_req_t   mem_req;
	nfam_pkg::state_set_t mem_rdata;
	nfam_pkg::seq_res_t   res;
	logic                 res_take;
	logic                 rsp_valid_q;
	nfam_pkg::rsp_item_t  rsp_q;

	nfam_edge_mem u_mem (
		.clk     (clk),
		.mem_req (mem_req),
		.rdata   (mem_rdata)
	);

	nfam_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.res       (res),
		.res_take  (res_take)
	);

	assign res_take = res.valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res.item;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[sv/nfam_edge_mem.sv]
module nfam_edge_mem (
	input  logic               clk,
	input  nfam_pkg::mem_req_t mem_req,
	output nfam_pkg::state_set_t rdata
);

	nfam_pkg::state_set_t mem [nfam_pkg::ROWS];

	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			mem[mem_req.waddr] <= mem_req.wdata;
		end
		rdata <= mem[mem_req.raddr];
	end

endmodule

[sv/nfam_seq.sv]
module nfam_seq (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  nfam_pkg::req_item_t                  req,
	input  logic                                 cfg_we,
	input  logic [nfam_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [nfam_pkg::CFG_W-1:0]           cfg_data,
	output nfam_pkg::mem_req_t                   mem_req,
	input  nfam_pkg::state_set_t                 mem_rdata,
	output nfam_pkg::seq_res_t                   res,
	input  logic                                 res_take
);

	typedef enum logic [5:0] {
		ST_CLEAR   = 6'b000001,
		ST_IDLE    = 6'b000010,
		ST_SCAN    = 6'b000100,
		ST_EDIT_RD = 6'b001000,
		ST_EDIT_WR = 6'b010000,
		ST_DONE    = 6'b100000
	} seq_state_t;

	seq_state_t                    state_q;
	logic [nfam_pkg::ROW_W-1:0]    clr_q;
	logic [nfam_pkg::ROW_W-1:0]    addr_q;
	logic [nfam_pkg::CNT_W-1:0]    cnt_q;
	logic                          rv_s1;
	logic [nfam_pkg::Q_W-1:0]      q_s1;
	nfam_pkg::state_set_t          active_q;
	nfam_pkg::state_set_t          next_q;
	nfam_pkg::state_set_t          bit_q;
	logic [1:0]                    kind_q;
	logic [1:0]                    status_q;
	logic [4:0]                    start_q;
	logic [31:0]                   final_q;

	logic                          accept;
	logic                          in_alpha;
	logic [nfam_pkg::SYM_W-1:0]    sidx;
	logic [nfam_pkg::ROW_W-1:0]    edit_row;
	logic                          edit_ok;
	nfam_pkg::state_set_t          to_bit;
	nfam_pkg::state_set_t          start_bits;
	nfam_pkg::state_set_t          final_ext;
	nfam_pkg::state_set_t          row_hit;
	logic                          edit_write;
	nfam_pkg::state_set_t          edit_data;

	assign accept    = req_valid && (state_q == ST_IDLE);
	assign req_stall = (state_q != ST_IDLE);

	always_comb begin
		in_alpha = (int'(req.symbol) >= nfam_pkg::ALPHABET_FIRST) &&
			(int'(req.symbol) < nfam_pkg::ALPHABET_FIRST + nfam_pkg::ALPHABET_LEN);
		sidx = nfam_pkg::SYM_W'(req.symbol - 8'(nfam_pkg::ALPHABET_FIRST));
		edit_row = nfam_pkg::ROW_W'(int'(req.from_state) * nfam_pkg::ALPHABET_LEN
			+ int'(sidx));
		edit_ok = (int'(req.from_state) < nfam_pkg::NUM_STATES) &&
			(int'(req.to_state) < nfam_pkg::NUM_STATES);
		to_bit = nfam_pkg::state_set_t'(1) << req.to_state;
		start_bits = (int'(start_q) < nfam_pkg::NUM_STATES) ?
			(nfam_pkg::state_set_t'(1) << start_q) : '0;
		final_ext = nfam_pkg::state_set_t'(final_q);
		row_hit = active_q[q_s1] ? mem_rdata : '0;
	end

	always_comb begin
		edit_write = 1'b0;
		edit_data  = mem_rdata;
		if (kind_q == nfam_pkg::KIND_ADD) begin
			edit_write = 1'b1;
			edit_data  = mem_rdata | bit_q;
		end else if ((mem_rdata & bit_q) != '0) begin
			edit_write = 1'b1;
			edit_data  = mem_rdata & ~bit_q;
		end
	end

	always_comb begin
		mem_req.raddr = addr_q;
		if (state_q == ST_CLEAR) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = clr_q;
			mem_req.wdata = '0;
		end else begin
			mem_req.we    = (state_q == ST_EDIT_WR) && edit_write;
			mem_req.waddr = addr_q;
			mem_req.wdata = edit_data;
		end
	end

	always_comb begin
		res.valid         = (state_q == ST_DONE);
		res.item.accepted = |(active_q & final_ext);
		res.item.alive    = |active_q;
		res.item.status   = status_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			final_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				nfam_pkg::REG_START_STATE: start_q <= cfg_data[4:0];
				nfam_pkg::REG_FINAL_MASK:  final_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			addr_q   <= '0;
			rv_s1    <= 1'b0;
			q_s1     <= '0;
			cnt_q    <= '0;
			active_q <= nfam_pkg::state_set_t'(1);
			next_q   <= '0;
			bit_q    <= '0;
			kind_q   <= nfam_pkg::KIND_SYMBOL;
			status_q <= nfam_pkg::STATUS_OK;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= nfam_pkg::ROW_W'(clr_q + 1'b1);
					if (clr_q == nfam_pkg::ROW_W'(nfam_pkg::ROWS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						status_q <= nfam_pkg::STATUS_OK;
						if (req.kind == nfam_pkg::KIND_RESTART) begin
							active_q <= start_bits;
							state_q  <= ST_DONE;
						end else if (!in_alpha) begin
							status_q <= nfam_pkg::STATUS_BAD_SYM;
							state_q  <= ST_DONE;
						end else if (req.kind == nfam_pkg::KIND_SYMBOL) begin
							addr_q  <= nfam_pkg::ROW_W'(sidx);
							cnt_q   <= '0;
							rv_s1   <= 1'b0;
							next_q  <= '0;
							state_q <= ST_SCAN;
						end else if (!edit_ok) begin
							if (req.kind == nfam_pkg::KIND_REMOVE) begin
								status_q <= nfam_pkg::STATUS_NOT_FOUND;
							end
							state_q <= ST_DONE;
						end else begin
							addr_q  <= edit_row;
							bit_q   <= to_bit;
							kind_q  <= req.kind;
							state_q <= ST_EDIT_RD;
						end
					end
				end
				ST_SCAN: begin
					if (cnt_q != nfam_pkg::CNT_W'(nfam_pkg::NUM_STATES)) begin
						rv_s1  <= 1'b1;
						q_s1   <= cnt_q[nfam_pkg::Q_W-1:0];
						cnt_q  <= nfam_pkg::CNT_W'(cnt_q + 1'b1);
						addr_q <= nfam_pkg::ROW_W'(int'(addr_q) + nfam_pkg::ALPHABET_LEN);
					end else begin
						rv_s1 <= 1'b0;
					end
					if (rv_s1) begin
						next_q <= next_q | row_hit;
						if (q_s1 == nfam_pkg::Q_W'(nfam_pkg::NUM_STATES - 1)) begin
							active_q <= next_q | row_hit;
							state_q  <= ST_DONE;
						end
					end
				end
				ST_EDIT_RD: begin
					state_q <= ST_EDIT_WR;
				end
				ST_EDIT_WR: begin
					if (!edit_write) begin
						status_q <= nfam_pkg::STATUS_NOT_FOUND;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

endmodule
